[hw/rtl/tbv_pkg.sv]
// Package for the tile background scanline video block.
// Holds the shared widths, mode and sequencer types, and the result record.
// No dependencies.
package tbv_pkg;

  localparam int ADDR_W      = 13;
  localparam int DATA_W      = 8;
  localparam int CFG_INDEX_W = 2;
  localparam int LINE_W      = 8;
  localparam int CLOCK_W     = 10;
  localparam int GROUP_W     = 5;
  localparam int PIX_W       = 16;
  localparam int MAX_GROUPS  = 20;

  localparam logic [CLOCK_W-1:0] HBLANK_CLOCKS = CLOCK_W'(204);
  localparam logic [CLOCK_W-1:0] VBLANK_CLOCKS = CLOCK_W'(456);
  localparam logic [CLOCK_W-1:0] OAM_CLOCKS    = CLOCK_W'(80);
  localparam logic [CLOCK_W-1:0] VRAM_CLOCKS   = CLOCK_W'(172);
  localparam logic [LINE_W-1:0]  VBLANK_LINE   = LINE_W'(144);
  localparam logic [LINE_W-1:0]  LAST_LINE     = LINE_W'(153);
  localparam logic [2:0]         FINE_MASK     = 3'b111;

  localparam logic [CFG_INDEX_W-1:0] CFG_SCROLL_X = CFG_INDEX_W'(0);
  localparam logic [CFG_INDEX_W-1:0] CFG_SCROLL_Y = CFG_INDEX_W'(1);

  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_WRITE = 1'b1;

  localparam logic KIND_STATUS = 1'b0;
  localparam logic KIND_PIXELS = 1'b1;

  typedef enum logic [1:0] {
    MODE_HBLANK = 2'd0,
    MODE_VBLANK = 2'd1,
    MODE_OAM    = 2'd2,
    MODE_VRAM   = 2'd3
  } mode_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_TICK,
    S_STATUS,
    S_MAP,
    S_LO,
    S_HI,
    S_CAT,
    S_EMIT
  } state_t;

  typedef struct packed {
    logic               kind;
    mode_t              mode;
    logic [LINE_W-1:0]  line;
    logic               frame;
    logic [GROUP_W-1:0] group;
    logic [PIX_W-1:0]   pixels;
    logic               last;
  } result_t;

  // Pack one tile row into eight 2-bit colors, leftmost pixel in the top bits.
  function automatic logic [PIX_W-1:0] tile_row_pixels(input logic [DATA_W-1:0] lo,
                                                       input logic [DATA_W-1:0] hi);
    logic [PIX_W-1:0] word;
    word = '0;
    for (int p = 0; p < 8; p++) begin
      word[2*p+1] = hi[p];
      word[2*p]   = lo[p];
    end
    return word;
  endfunction

endpackage

[hw/rtl/tbv_if.sv]
// Channel interfaces of the tile background scanline video block.
// Item, result and configuration channels; depends on tbv_pkg.
interface tbv_item_if import tbv_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              opcode;
  logic [ADDR_W-1:0] vram_address;
  logic [DATA_W-1:0] vram_data;
  logic [DATA_W-1:0] elapsed;

  modport source (output valid, opcode, vram_address, vram_data, elapsed, input ready);
  modport sink   (input valid, opcode, vram_address, vram_data, elapsed, output ready);
endinterface

interface tbv_result_if import tbv_pkg::*; ();
  logic               valid;
  logic               ready;
  logic               kind;
  logic [1:0]         video_mode;
  logic [LINE_W-1:0]  scan_line;
  logic               frame_done;
  logic [GROUP_W-1:0] group_index;
  logic [PIX_W-1:0]   pixels;
  logic               last;

  modport source (output valid, kind, video_mode, scan_line, frame_done, group_index,
                  pixels, last, input ready);
  modport sink   (input valid, kind, video_mode, scan_line, frame_done, group_index,
                  pixels, last, output ready);
endinterface

interface tbv_cfg_if import tbv_pkg::*; ();
  logic                   valid;
  logic                   ready;
  logic [CFG_INDEX_W-1:0] index;
  logic [DATA_W-1:0]      data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

[hw/rtl/tbv_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// Used for video memory; no dependencies.
module tbv_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

[hw/rtl/tile_background_scanline_video.sv]
// Video timing and tile background renderer. A byte write reaches video memory in the same
// cycle as it is accepted. A tick goes through S_TICK and S_STATUS, which waits for the output
// register to be free and loads the status into it, then returns to idle unless the tick ends
// VRAM read. Such a tick fetches SCREEN_WIDTH/8 + 1 tiles (at most 21) through the single
// video memory read port, each via S_MAP, S_LO, S_HI, S_CAT and S_EMIT, for up to 20 pixel
// groups. After reset a clearing pass zeroes all 8192 words of video memory with no item
// accepted; configuration writes are taken throughout. Depends on tbv_pkg, tbv_if, tbv_ram.
module tile_background_scanline_video import tbv_pkg::*; #(
  parameter int SCREEN_WIDTH = 160,
  parameter int MAP_BASE     = 6144,
  parameter int TILE_BASE    = 0
) (
  input  logic         clk,
  input  logic         rst,
  tbv_item_if.sink     item,
  tbv_result_if.source result,
  tbv_cfg_if.sink      cfg
);

  localparam int GROUPS = (SCREEN_WIDTH / 8 > MAX_GROUPS) ? MAX_GROUPS : SCREEN_WIDTH / 8;
  localparam logic [GROUP_W-1:0] LAST_TILE = GROUP_W'(GROUPS);
  localparam logic [ADDR_W-1:0]  MAP_ADDR  = ADDR_W'(MAP_BASE);
  localparam logic [ADDR_W-1:0]  TILE_ADDR = ADDR_W'(TILE_BASE);

  state_t state, state_next;

  logic [DATA_W-1:0]  scroll_x, scroll_y;
  mode_t              mode_reg, mode_next;
  logic [CLOCK_W-1:0] mode_clock, mode_clock_next;
  logic [LINE_W-1:0]  line_count, line_next;
  logic               frame_flag, frame_next;
  logic               render_flag, render_next;
  logic [DATA_W-1:0]  elapsed_reg;
  logic [ADDR_W-1:0]  clear_addr;
  logic [GROUP_W-1:0] tile_idx;
  logic [ADDR_W-1:0]  row_addr;
  logic [DATA_W-1:0]  lo_byte;
  logic [PIX_W-1:0]   prev_word, cur_word;

  logic               out_valid;
  result_t            res, res_next;
  logic               out_free, load_out;

  logic               ram_we;
  logic [ADDR_W-1:0]  ram_waddr, ram_raddr, row_addr_calc;
  logic [DATA_W-1:0]  ram_wdata, ram_rdata;

  logic [CLOCK_W-1:0] clock_sum;
  logic [LINE_W-1:0]  bg_y, line_inc;
  logic [4:0]         map_col;
  logic [2*PIX_W-1:0] window;
  logic               item_accept;

  tbv_ram #(.WIDTH(DATA_W), .DEPTH(1 << ADDR_W)) u_vram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  assign item_accept = item.valid && item.ready;
  assign out_free    = !out_valid || result.ready;
  assign cfg.ready   = 1'b1;

  assign result.valid       = out_valid;
  assign result.kind        = res.kind;
  assign result.video_mode  = res.mode;
  assign result.scan_line   = res.line;
  assign result.frame_done  = res.frame;
  assign result.group_index = res.group;
  assign result.pixels      = res.pixels;
  assign result.last        = res.last;

  // Background coordinates: row wraps at 256, tile column wraps within the map row.
  assign bg_y          = line_count + scroll_y;
  assign map_col       = scroll_x[7:3] + tile_idx;
  assign row_addr_calc = TILE_ADDR + {1'b0, ram_rdata, 4'b0}
                         + {{(ADDR_W-4){1'b0}}, bg_y[2:0] & FINE_MASK, 1'b0};
  assign window        = {prev_word, cur_word} << {scroll_x[2:0], 1'b0};

  // Mode timing for one tick.
  assign clock_sum = mode_clock + {{(CLOCK_W-DATA_W){1'b0}}, elapsed_reg};
  assign line_inc  = line_count + LINE_W'(1);

  always_comb begin
    mode_next       = mode_reg;
    mode_clock_next = clock_sum;
    line_next       = line_count;
    frame_next      = 1'b0;
    render_next     = 1'b0;
    unique case (mode_reg)
      MODE_HBLANK: begin
        if (clock_sum >= HBLANK_CLOCKS) begin
          mode_clock_next = '0;
          line_next       = line_inc;
          if (line_inc == VBLANK_LINE) begin
            mode_next  = MODE_VBLANK;
            frame_next = 1'b1;
          end else begin
            mode_next = MODE_OAM;
          end
        end
      end
      MODE_VBLANK: begin
        if (clock_sum >= VBLANK_CLOCKS) begin
          mode_clock_next = '0;
          line_next       = line_inc;
          if (line_inc > LAST_LINE) begin
            mode_next = MODE_OAM;
            line_next = '0;
          end
        end
      end
      MODE_OAM: begin
        if (clock_sum >= OAM_CLOCKS) begin
          mode_clock_next = '0;
          mode_next       = MODE_VRAM;
        end
      end
      MODE_VRAM: begin
        if (clock_sum >= VRAM_CLOCKS) begin
          mode_clock_next = '0;
          mode_next       = MODE_HBLANK;
          render_next     = 1'b1;
        end
      end
    endcase
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_CLEAR:  if (clear_addr == '1) state_next = S_IDLE;
      S_IDLE:   if (item_accept && item.opcode == OP_TICK) state_next = S_TICK;
      S_TICK:   state_next = S_STATUS;
      S_STATUS: if (out_free) state_next = render_flag ? S_MAP : S_IDLE;
      S_MAP:    state_next = S_LO;
      S_LO:     state_next = S_HI;
      S_HI:     state_next = S_CAT;
      S_CAT:    state_next = S_EMIT;
      S_EMIT: begin
        if (tile_idx == '0) begin
          state_next = S_MAP;
        end else if (out_free) begin
          state_next = (tile_idx == LAST_TILE) ? S_IDLE : S_MAP;
        end
      end
    endcase
  end

  // Outputs of the sequencer: memory port, handshake and result record.
  always_comb begin
    item.ready = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = item.vram_address;
    ram_wdata  = item.vram_data;
    ram_raddr  = row_addr + ADDR_W'(1);
    load_out   = 1'b0;
    res_next   = '{kind: KIND_STATUS, mode: mode_reg, line: line_count, frame: frame_flag,
                   group: '0, pixels: '0, last: !render_flag};
    unique case (state)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clear_addr;
        ram_wdata = '0;
      end
      S_IDLE: begin
        item.ready = 1'b1;
        ram_we     = item.valid && item.opcode == OP_WRITE;
      end
      S_TICK: ;
      S_STATUS: load_out = out_free;
      S_MAP:    ram_raddr = MAP_ADDR + {{(ADDR_W-10){1'b0}}, bg_y[7:3], map_col};
      S_LO:     ram_raddr = row_addr_calc;
      S_HI: ;
      S_CAT: ;
      S_EMIT: begin
        load_out       = out_free && tile_idx != '0;
        res_next.kind   = KIND_PIXELS;
        res_next.frame  = 1'b0;
        res_next.group  = tile_idx - GROUP_W'(1);
        res_next.pixels = window[2*PIX_W-1:PIX_W];
        res_next.last   = tile_idx == LAST_TILE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_CLEAR;
      clear_addr <= '0;
      scroll_x   <= '0;
      scroll_y   <= '0;
      mode_reg   <= MODE_HBLANK;
      mode_clock <= '0;
      line_count <= '0;
      out_valid  <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_CLEAR) begin
        clear_addr <= clear_addr + ADDR_W'(1);
      end
      if (cfg.valid) begin
        unique case (cfg.index)
          CFG_SCROLL_X: scroll_x <= cfg.data;
          CFG_SCROLL_Y: scroll_y <= cfg.data;
          default: ;
        endcase
      end
      if (state == S_TICK) begin
        mode_reg   <= mode_next;
        mode_clock <= mode_clock_next;
        line_count <= line_next;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (item_accept) begin
      elapsed_reg <= item.elapsed;
    end
    if (state == S_TICK) begin
      frame_flag  <= frame_next;
      render_flag <= render_next;
      tile_idx    <= '0;
    end
    if (state == S_LO) begin
      row_addr <= row_addr_calc;
    end
    if (state == S_HI) begin
      lo_byte <= ram_rdata;
    end
    if (state == S_CAT) begin
      prev_word <= cur_word;
      cur_word  <= tile_row_pixels(lo_byte, ram_rdata);
    end
    if (state == S_EMIT && state_next == S_MAP) begin
      tile_idx <= tile_idx + GROUP_W'(1);
    end
    if (load_out) begin
      res <= res_next;
    end
  end

  a_clock_range: assert property (@(posedge clk) disable iff (rst)
    mode_clock < VBLANK_CLOCKS)
    else $error("mode clock left its range");

  a_line_range: assert property (@(posedge clk) disable iff (rst)
    line_count <= LAST_LINE)
    else $error("line count beyond last line");

  a_pixels_in_hblank: assert property (@(posedge clk) disable iff (rst)
    load_out && res_next.kind == KIND_PIXELS |-> mode_reg == MODE_HBLANK)
    else $error("pixel group produced outside horizontal blank");

  a_frame_line: assert property (@(posedge clk) disable iff (rst)
    out_valid && res.frame |-> res.mode == MODE_VBLANK && res.line == VBLANK_LINE)
    else $error("frame done without entry to vertical blank");

  a_no_item_in_clear: assert property (@(posedge clk) disable iff (rst)
    state == S_CLEAR |=> !$past(item_accept))
    else $error("item accepted during memory clear");

endmodule

[sim/tb_top.sv]
// Testbench for tile_background_scanline_video: video memory writes and timing ticks
// are checked against a cycle-free model of the mode timing and the background renderer.
// Depends on tbv_pkg, tbv_if and the RTL of the block.
`timescale 1ns / 100ps

module tb_top;
  import tbv_pkg::*;

  localparam int SCREEN_W      = 160;
  localparam int MAP_START     = 6144;
  localparam int TILE_START    = 0;
  localparam int GROUP_COUNT   = (SCREEN_W / 8 > MAX_GROUPS) ? MAX_GROUPS : SCREEN_W / 8;
  localparam int SETTLE_CYCLES = 16;
  localparam int RANDOM_ITEMS  = 160;
  localparam int HOLD_CYCLES   = 400;

  // Index codes that decode to no register; the block must ignore them.
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_A = CFG_INDEX_W'(2);
  localparam logic [CFG_INDEX_W-1:0] CFG_SPARE_B = CFG_INDEX_W'(3);

  typedef struct {
    logic              opcode;
    logic [ADDR_W-1:0] vram_address;
    logic [DATA_W-1:0] vram_data;
    logic [DATA_W-1:0] elapsed;
  } video_item_t;

  logic clk;
  logic rst;

  tbv_item_if   item_ch ();
  tbv_result_if result_ch ();
  tbv_cfg_if    cfg_ch ();

  tile_background_scanline_video #(
    .SCREEN_WIDTH(SCREEN_W),
    .MAP_BASE    (MAP_START),
    .TILE_BASE   (TILE_START)
  ) uut (
    .clk   (clk),
    .rst   (rst),
    .item  (item_ch),
    .result(result_ch),
    .cfg   (cfg_ch)
  );

  video_item_t pending_video_items[$];
  result_t     expected_video_results[$];

  // Shadow of the block's state, updated on each accepted transaction.
  logic [DATA_W-1:0] vram_shadow [8192];
  logic [DATA_W-1:0] scroll_x_shadow = '0;
  logic [DATA_W-1:0] scroll_y_shadow = '0;
  mode_t             mode_shadow     = MODE_HBLANK;
  int unsigned       dot_clock       = 0;
  logic [LINE_W-1:0] line_shadow     = '0;

  int   error_count = 0;
  int   gap_left    = 0;
  int   stall_left  = 0;
  bit   idling_on   = 1'b1;
  bit   pressure_go = 1'b0;
  logic hold_off    = 1'b0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #10_000_000;
    $display("DONE: errors detected");
    $finish;
  end

  function automatic logic [1:0] background_color(input int unsigned line_no,
                                                  input int unsigned screen_x);
    int unsigned bg_y, bg_x, map_addr, row_addr, bit_pos;
    logic [DATA_W-1:0] tile_id, plane_lo, plane_hi;
    bg_y     = (line_no + scroll_y_shadow) & 255;
    bg_x     = (screen_x + scroll_x_shadow) & 255;
    map_addr = (MAP_START + (bg_y >> 3) * 32 + (bg_x >> 3)) & 13'h1FFF;
    tile_id  = vram_shadow[map_addr];
    row_addr = (TILE_START + tile_id * 16 + 2 * (bg_y & 7)) & 13'h1FFF;
    plane_lo = vram_shadow[row_addr];
    plane_hi = vram_shadow[(row_addr + 1) & 13'h1FFF];
    bit_pos  = 7 - (bg_x & 7);
    return {plane_hi[bit_pos], plane_lo[bit_pos]};
  endfunction

  // Moves the mode timing on by one tick and queues the status and any rendered line.
  task automatic advance_video_timing(input logic [DATA_W-1:0] clocks);
    result_t          entry;
    logic             render;
    logic             frame;
    logic [PIX_W-1:0] word;
    render    = 1'b0;
    frame     = 1'b0;
    dot_clock = dot_clock + clocks;
    case (mode_shadow)
      MODE_HBLANK: begin
        if (dot_clock >= HBLANK_CLOCKS) begin
          dot_clock   = 0;
          line_shadow = line_shadow + 1'b1;
          if (line_shadow == VBLANK_LINE) begin
            mode_shadow = MODE_VBLANK;
            frame       = 1'b1;
          end else begin
            mode_shadow = MODE_OAM;
          end
        end
      end
      MODE_VBLANK: begin
        if (dot_clock >= VBLANK_CLOCKS) begin
          dot_clock   = 0;
          line_shadow = line_shadow + 1'b1;
          if (line_shadow > LAST_LINE) begin
            mode_shadow = MODE_OAM;
            line_shadow = '0;
          end
        end
      end
      MODE_OAM: begin
        if (dot_clock >= OAM_CLOCKS) begin
          dot_clock   = 0;
          mode_shadow = MODE_VRAM;
        end
      end
      default: begin
        if (dot_clock >= VRAM_CLOCKS) begin
          dot_clock   = 0;
          mode_shadow = MODE_HBLANK;
          render      = 1'b1;
        end
      end
    endcase
    entry.kind   = KIND_STATUS;
    entry.mode   = mode_shadow;
    entry.line   = line_shadow;
    entry.frame  = frame;
    entry.group  = '0;
    entry.pixels = '0;
    entry.last   = !render;
    expected_video_results.insert(expected_video_results.size(), entry);
    if (render) begin
      for (int g = 0; g < GROUP_COUNT; g++) begin
        word = '0;
        for (int p = 0; p < 8; p++) begin
          word = {word[PIX_W-3:0], background_color(line_shadow, g * 8 + p)};
        end
        entry.kind   = KIND_PIXELS;
        entry.frame  = 1'b0;
        entry.group  = GROUP_W'(g);
        entry.pixels = word;
        entry.last   = (g == GROUP_COUNT - 1);
        expected_video_results.insert(expected_video_results.size(), entry);
      end
    end
  endtask

  function automatic video_item_t vram_write_item(input int unsigned addr,
                                                  input logic [DATA_W-1:0] value);
    video_item_t it;
    it.opcode       = OP_WRITE;
    it.vram_address = ADDR_W'(addr);
    it.vram_data    = value;
    it.elapsed      = DATA_W'($urandom);
    return it;
  endfunction

  function automatic video_item_t tick_item(input logic [DATA_W-1:0] clocks);
    video_item_t it;
    it.opcode       = OP_TICK;
    it.vram_address = ADDR_W'($urandom);
    it.vram_data    = DATA_W'($urandom);
    it.elapsed      = clocks;
    return it;
  endfunction

  // Mostly ticks long enough to finish any mode but vertical blank;
  // writes land mainly on the map and on the first few tiles that the map points at.
  function automatic video_item_t random_video_item();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 11) begin
      case ($urandom_range(0, 4))
        0, 1: return vram_write_item(MAP_START + $urandom_range(0, 1023),
                                     DATA_W'($urandom_range(0, 7)));
        2, 3: return vram_write_item(TILE_START + $urandom_range(0, 127), DATA_W'($urandom));
        default: return vram_write_item($urandom_range(0, 8191), DATA_W'($urandom));
      endcase
    end else if (pick < 20) begin
      return tick_item(DATA_W'($urandom_range(0, 255)));
    end
    return tick_item(DATA_W'($urandom_range(228, 255)));
  endfunction

  task automatic enqueue_item(input video_item_t it);
    pending_video_items.insert(pending_video_items.size(), it);
  endtask

  task automatic write_scroll_register(input logic [CFG_INDEX_W-1:0] idx,
                                       input logic [DATA_W-1:0] value);
    @(posedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    if (idx == CFG_SCROLL_X) scroll_x_shadow = value;
    else if (idx == CFG_SCROLL_Y) scroll_y_shadow = value;
    cfg_ch.valid <= 1'b0;
  endtask

  // Sampled on the falling edge so that the driver's and monitor's updates have settled.
  task automatic wait_until_quiet();
    while (pending_video_items.size() != 0 || item_ch.valid ||
           expected_video_results.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic compare_field(input string name, input int unsigned want,
                               input int unsigned got);
    if (want != got) begin
      error_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin
    video_item_t next_item;
    if (rst) begin
      item_ch.valid <= 1'b0;
      gap_left = 0;
    end else begin
      if (item_ch.valid && item_ch.ready) begin
        if (item_ch.opcode == OP_WRITE) vram_shadow[item_ch.vram_address] = item_ch.vram_data;
        else advance_video_timing(item_ch.elapsed);
      end
      if (!item_ch.valid || item_ch.ready) begin
        if (gap_left > 0) begin
          gap_left--;
          item_ch.valid <= 1'b0;
        end else if (idling_on && $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(0, 12);
          item_ch.valid <= 1'b0;
        end else if (pending_video_items.size() != 0) begin
          next_item = pending_video_items.pop_front();
          item_ch.valid        <= 1'b1;
          item_ch.opcode       <= next_item.opcode;
          item_ch.vram_address <= next_item.vram_address;
          item_ch.vram_data    <= next_item.vram_data;
          item_ch.elapsed      <= next_item.elapsed;
        end else begin
          item_ch.valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    result_t want;
    if (rst) begin
      result_ch.ready <= 1'b0;
      stall_left = 0;
    end else begin
      if (result_ch.valid && result_ch.ready) begin
        if (expected_video_results.size() == 0) begin
          error_count++;
          $display("%0t: unexpected result, expected none, actual kind %0d line %0d group %0d",
                   $time, result_ch.kind, result_ch.scan_line, result_ch.group_index);
        end else begin
          want = expected_video_results.pop_front();
          compare_field("kind", want.kind, result_ch.kind);
          compare_field("video_mode", want.mode, result_ch.video_mode);
          compare_field("scan_line", want.line, result_ch.scan_line);
          compare_field("frame_done", want.frame, result_ch.frame_done);
          compare_field("group_index", want.group, result_ch.group_index);
          compare_field("pixels", want.pixels, result_ch.pixels);
          compare_field("last", want.last, result_ch.last);
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        result_ch.ready <= 1'b0;
      end else if (idling_on && $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 12);
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= !hold_off;
      end
    end
  end

  // Long receiver hold-off while items keep coming, so the block backs up into its input.
  initial begin
    wait (pressure_go);
    repeat (40) @(posedge clk);
    hold_off <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_off <= 1'b0;
  end

  initial begin
    rst                  = 1'b1;
    item_ch.valid        = 1'b0;
    item_ch.opcode       = OP_TICK;
    item_ch.vram_address = '0;
    item_ch.vram_data    = '0;
    item_ch.elapsed      = '0;
    result_ch.ready      = 1'b0;
    cfg_ch.valid         = 1'b0;
    cfg_ch.index         = CFG_SCROLL_X;
    cfg_ch.data          = '0;
    for (int a = 0; a < 8192; a++) vram_shadow[a] = '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;

    write_scroll_register(CFG_SCROLL_X, 8'h00);
    write_scroll_register(CFG_SCROLL_Y, 8'h00);

    // Tile 0 and tile 1 rows 0 and 1, a few map entries, and both address extremes.
    enqueue_item(vram_write_item(0, 8'hFF));
    enqueue_item(vram_write_item(1, 8'h0F));
    enqueue_item(vram_write_item(2, 8'hF0));
    enqueue_item(vram_write_item(3, 8'hCC));
    enqueue_item(vram_write_item(16, 8'hA5));
    enqueue_item(vram_write_item(17, 8'h3C));
    enqueue_item(vram_write_item(18, 8'h81));
    enqueue_item(vram_write_item(19, 8'h7E));
    enqueue_item(vram_write_item(MAP_START + 1, 8'h01));
    enqueue_item(vram_write_item(MAP_START + 1023, 8'hFF));
    enqueue_item(vram_write_item(8191, 8'hFF));
    // Zero tick, thresholds met exactly and just missed, excess clocks dropped.
    enqueue_item(tick_item(8'd0));
    enqueue_item(tick_item(8'd203));
    enqueue_item(tick_item(8'd1));
    enqueue_item(tick_item(8'd79));
    enqueue_item(tick_item(8'd1));
    enqueue_item(tick_item(8'd255));
    enqueue_item(tick_item(8'd255));
    enqueue_item(tick_item(8'd255));
    enqueue_item(tick_item(8'd172));
    enqueue_item(tick_item(8'd204));
    wait_until_quiet();

    write_scroll_register(CFG_SCROLL_X, 8'hFF);
    write_scroll_register(CFG_SCROLL_Y, 8'hFF);
    write_scroll_register(CFG_SPARE_A, 8'h5A);
    for (int n = 0; n < RANDOM_ITEMS; n++) enqueue_item(random_video_item());
    pressure_go = 1'b1;
    wait_until_quiet();

    write_scroll_register(CFG_SCROLL_X, DATA_W'($urandom));
    write_scroll_register(CFG_SCROLL_Y, DATA_W'($urandom));
    write_scroll_register(CFG_SPARE_B, DATA_W'($urandom));
    for (int n = 0; n < RANDOM_ITEMS; n++) enqueue_item(random_video_item());
    wait_until_quiet();

    // Final stretch runs at full rate on both sides.
    idling_on = 1'b0;
    write_scroll_register(CFG_SCROLL_X, 8'd3);
    write_scroll_register(CFG_SCROLL_Y, 8'd250);
    for (int n = 0; n < RANDOM_ITEMS; n++) enqueue_item(random_video_item());
    wait_until_quiet();

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
